/* design/lmfc_pkg.sv */
package lmfc_pkg;

  // Operation codes of an input word
  localparam logic [2:0] OP_INIT    = 3'd0;
  localparam logic [2:0] OP_CLEAR   = 3'd1;
  localparam logic [2:0] OP_PUT     = 3'd2;
  localparam logic [2:0] OP_DIGIT   = 3'd3;
  localparam logic [2:0] OP_REFRESH = 3'd4;

  // Microprogram addresses
  localparam logic [3:0] STEP_IDLE     = 4'd0;
  localparam logic [3:0] STEP_INIT     = 4'd1;
  localparam logic [3:0] STEP_INIT_CLR = 4'd2;
  localparam logic [3:0] STEP_CLEAR    = 4'd3;
  localparam logic [3:0] STEP_PUT      = 4'd4;
  localparam logic [3:0] STEP_DCHK     = 4'd5;
  localparam logic [3:0] STEP_DPIX     = 4'd6;
  localparam logic [3:0] STEP_DDONE    = 4'd7;
  localparam logic [3:0] STEP_BAD      = 4'd8;
  localparam logic [3:0] STEP_REFRESH  = 4'd9;

  localparam logic [3:0] INIT_LAST    = 4'd9;
  localparam logic [3:0] GLYPH_LAST   = 4'd14;
  localparam logic [3:0] REFRESH_LAST = 4'd15;

  localparam logic [2:0] INTENSITY_RESET = 3'd1;

  typedef enum logic [1:0] {
    EM_NONE,
    EM_INIT,
    EM_REFRESH,
    EM_STATUS
  } emit_t;

  typedef enum logic [1:0] {
    OK_ONE,
    OK_ZERO,
    OK_PIXEL
  } ok_sel_t;

  typedef enum logic [1:0] {
    FB_NONE,
    FB_CLEAR,
    FB_PUT,
    FB_GLYPH
  } fb_op_t;

  typedef enum logic [1:0] {
    SQ_WAIT,
    SQ_LOOP,
    SQ_GOTO,
    SQ_BADCHAR
  } seq_t;

  typedef struct packed {
    emit_t      emit;
    ok_sel_t    ok_sel;
    fb_op_t     fb_op;
    seq_t       seq;
    logic [3:0] target;
    logic [3:0] limit;
  } ctrl_word_t;

  // Sequencer to datapath
  typedef struct packed {
    ctrl_word_t word;
    logic [3:0] pc;
    logic [3:0] cnt;
    logic       advance;
    logic       loop_done;
    logic       load_item;
  } ctrl_t;

  // Datapath to sequencer
  typedef struct packed {
    logic stall;
    logic char_bad;
  } dp_stat_t;

  function automatic ctrl_word_t ucode(input logic [3:0] pc);
    ctrl_word_t w;
    w = '{emit: EM_NONE, ok_sel: OK_ONE, fb_op: FB_NONE, seq: SQ_GOTO,
          target: STEP_IDLE, limit: 4'd0};
    case (pc)
      STEP_IDLE: begin
        w.seq = SQ_WAIT;
      end
      STEP_INIT: begin
        w.emit = EM_INIT;
        w.seq = SQ_LOOP;
        w.target = STEP_INIT;
        w.limit = INIT_LAST;
      end
      STEP_INIT_CLR: begin
        w.fb_op = FB_CLEAR;
      end
      STEP_CLEAR: begin
        w.fb_op = FB_CLEAR;
        w.emit = EM_STATUS;
      end
      STEP_PUT: begin
        w.fb_op = FB_PUT;
        w.emit = EM_STATUS;
        w.ok_sel = OK_PIXEL;
      end
      STEP_DCHK: begin
        w.seq = SQ_BADCHAR;
        w.target = STEP_BAD;
      end
      STEP_DPIX: begin
        w.fb_op = FB_GLYPH;
        w.seq = SQ_LOOP;
        w.target = STEP_DPIX;
        w.limit = GLYPH_LAST;
      end
      STEP_DDONE: begin
        w.emit = EM_STATUS;
      end
      STEP_BAD: begin
        w.emit = EM_STATUS;
        w.ok_sel = OK_ZERO;
      end
      STEP_REFRESH: begin
        w.emit = EM_REFRESH;
        w.seq = SQ_LOOP;
        w.target = STEP_REFRESH;
        w.limit = REFRESH_LAST;
      end
      default: begin
        w.seq = SQ_GOTO;
      end
    endcase
    return w;
  endfunction

  function automatic logic [3:0] dispatch(input logic [2:0] op);
    logic [3:0] t;
    case (op)
      OP_INIT:    t = STEP_INIT;
      OP_CLEAR:   t = STEP_CLEAR;
      OP_PUT:     t = STEP_PUT;
      OP_DIGIT:   t = STEP_DCHK;
      OP_REFRESH: t = STEP_REFRESH;
      default:    t = STEP_BAD;
    endcase
    return t;
  endfunction

  // Setup command for frame idx of init
  function automatic logic [15:0] init_word(input logic [2:0] idx,
                                            input logic [3:0] inten);
    logic [15:0] w;
    case (idx)
      3'd0:    w = 16'h0F00;
      3'd1:    w = 16'h0B07;
      3'd2:    w = 16'h0900;
      3'd3:    w = 16'h0C01;
      default: w = {12'h0A0, inten};
    endcase
    return w;
  endfunction

  // 3x5 digit font, five rows per digit, bit 0 is the rightmost pixel
  localparam logic [2:0] GLYPHS [0:49] = '{
    3'd2, 3'd5, 3'd5, 3'd5, 3'd2,
    3'd2, 3'd6, 3'd2, 3'd2, 3'd7,
    3'd6, 3'd1, 3'd2, 3'd4, 3'd7,
    3'd6, 3'd1, 3'd2, 3'd1, 3'd6,
    3'd4, 3'd4, 3'd7, 3'd2, 3'd2,
    3'd7, 3'd4, 3'd2, 3'd1, 3'd6,
    3'd2, 3'd4, 3'd6, 3'd5, 3'd2,
    3'd7, 3'd1, 3'd1, 3'd2, 3'd2,
    3'd2, 3'd5, 3'd7, 3'd5, 3'd2,
    3'd2, 3'd5, 3'd3, 3'd1, 3'd2
  };

  // Split a pixel count 0..14 into glyph row (count / 3) and bit (count % 3)
  function automatic logic [4:0] glyph_pos(input logic [3:0] c);
    logic [4:0] rb;
    case (c)
      4'd0:    rb = {3'd0, 2'd0};
      4'd1:    rb = {3'd0, 2'd1};
      4'd2:    rb = {3'd0, 2'd2};
      4'd3:    rb = {3'd1, 2'd0};
      4'd4:    rb = {3'd1, 2'd1};
      4'd5:    rb = {3'd1, 2'd2};
      4'd6:    rb = {3'd2, 2'd0};
      4'd7:    rb = {3'd2, 2'd1};
      4'd8:    rb = {3'd2, 2'd2};
      4'd9:    rb = {3'd3, 2'd0};
      4'd10:   rb = {3'd3, 2'd1};
      4'd11:   rb = {3'd3, 2'd2};
      4'd12:   rb = {3'd4, 2'd0};
      4'd13:   rb = {3'd4, 2'd1};
      default: rb = {3'd4, 2'd2};
    endcase
    return rb;
  endfunction

endpackage

/* design/led_matrix_framebuffer_controller_unit.sv */
// The input word is accepted in the idle step; the routine's emitting steps register the result words.
// draw_digit answers after its glyph pixels, or right after the digit check for a character that is not a digit.
// Each operation runs one step per command word or glyph pixel plus idle and closing steps;
// output back-pressure holds the steps that emit a word. A new input word is accepted only
// in the idle step, so each operation finishes before the next is taken.
// Reset: synchronous; clears the framebuffer and sets intensity to 1.
module led_matrix_framebuffer_controller_unit (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [2:0]        operation,
  input  logic signed [5:0] pos_x,
  input  logic signed [4:0] pos_y,
  input  logic              pixel_on,
  input  logic [7:0]        char_code,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [15:0]       spi_word,
  output logic              word_valid,
  output logic              frame_end,
  output logic              ok,
  output logic              last,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [3:0]        intensity
);
  import lmfc_pkg::*;

  ctrl_t    ctrl;
  dp_stat_t stat;

  assign in_ready = (ctrl.word.seq == SQ_WAIT);
  assign cfg_ready = 1'b1;

  lmfc_seq u_seq (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .operation (operation),
    .stat      (stat),
    .ctrl      (ctrl)
  );

  lmfc_dp u_dp (
    .clk        (clk),
    .rst        (rst),
    .ctrl       (ctrl),
    .pos_x      (pos_x),
    .pos_y      (pos_y),
    .pixel_on   (pixel_on),
    .char_code  (char_code),
    .cfg_valid  (cfg_valid),
    .intensity  (intensity),
    .out_ready  (out_ready),
    .out_valid  (out_valid),
    .spi_word   (spi_word),
    .word_valid (word_valid),
    .frame_end  (frame_end),
    .ok         (ok),
    .last       (last),
    .stat       (stat)
  );

  a_refresh_dispatch: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && operation == OP_REFRESH |=> ctrl.pc == STEP_REFRESH)
    else $error("refresh word did not start the refresh routine");

  a_last_ends_frame: assert property (@(posedge clk) disable iff (rst)
    out_valid && word_valid && last |-> frame_end)
    else $error("final command word does not end a frame");

  a_status_quiet: assert property (@(posedge clk) disable iff (rst)
    out_valid && !word_valid |-> spi_word == 16'h0000 && !frame_end && last)
    else $error("status word carries command data");

  a_busy_no_accept: assert property (@(posedge clk) disable iff (rst)
    ctrl.pc != STEP_IDLE |-> !in_ready)
    else $error("input accepted while a routine runs");

endmodule

/* design/lmfc_seq.sv */
module lmfc_seq (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  input  logic [2:0]       operation,
  input  lmfc_pkg::dp_stat_t stat,
  output lmfc_pkg::ctrl_t  ctrl
);
  import lmfc_pkg::*;

  logic [3:0] pc, pc_next;
  logic [3:0] cnt, cnt_next;
  ctrl_word_t word;
  logic       loop_done;
  logic       advance;

  assign word = ucode(pc);
  assign loop_done = (word.seq != SQ_LOOP) || (cnt == word.limit);
  // idle step waits for an input word, steps that emit hold while the output is full
  assign advance = (word.seq == SQ_WAIT) ? in_valid : !stat.stall;

  always_comb begin
    pc_next = pc;
    cnt_next = cnt;
    if (advance) begin
      case (word.seq)
        SQ_WAIT:    pc_next = dispatch(operation);
        SQ_LOOP:    pc_next = loop_done ? pc + 4'd1 : word.target;
        SQ_BADCHAR: pc_next = stat.char_bad ? word.target : pc + 4'd1;
        default:    pc_next = word.target;
      endcase
      cnt_next = (word.seq == SQ_LOOP && !loop_done) ? cnt + 4'd1 : 4'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pc <= STEP_IDLE;
      cnt <= 4'd0;
    end else begin
      pc <= pc_next;
      cnt <= cnt_next;
    end
  end

  assign ctrl.word = word;
  assign ctrl.pc = pc;
  assign ctrl.cnt = cnt;
  assign ctrl.advance = advance;
  assign ctrl.loop_done = loop_done;
  assign ctrl.load_item = advance && (word.seq == SQ_WAIT);

endmodule

/* design/lmfc_dp.sv */
module lmfc_dp (
  input  logic               clk,
  input  logic               rst,
  input  lmfc_pkg::ctrl_t    ctrl,
  input  logic signed [5:0]  pos_x,
  input  logic signed [4:0]  pos_y,
  input  logic               pixel_on,
  input  logic [7:0]         char_code,
  input  logic               cfg_valid,
  input  logic [3:0]         intensity,
  input  logic               out_ready,
  output logic               out_valid,
  output logic [15:0]        spi_word,
  output logic               word_valid,
  output logic               frame_end,
  output logic               ok,
  output logic               last,
  output lmfc_pkg::dp_stat_t stat
);
  import lmfc_pkg::*;

  logic [5:0] item_x;
  logic [4:0] item_y;
  logic       item_on;
  logic [7:0] item_char;
  logic [3:0] inten;

  logic [7:0] fb [0:15];

  logic       put_in;
  logic [4:0] gpos;
  logic [2:0] g_row;
  logic [1:0] g_bit;
  logic [5:0] g_idx;
  logic [6:0] gx;
  logic [5:0] gy;
  logic       g_in;
  logic [2:0] g_line;

  logic       wr_en;
  logic [3:0] wr_col;
  logic [2:0] wr_row;
  logic       wr_val;

  logic [2:0] rf_row;
  logic [3:0] rf_col;

  logic       emit_busy;
  logic       load;
  logic [15:0] n_word;
  logic       n_valid, n_fend, n_ok, n_last;

  always_ff @(posedge clk) begin
    if (ctrl.load_item) begin
      item_x <= pos_x;
      item_y <= pos_y;
      item_on <= pixel_on;
      item_char <= char_code;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      inten <= {1'b0, INTENSITY_RESET};
    end else if (cfg_valid) begin
      inten <= intensity;
    end
  end

  assign stat.char_bad = (item_char < 8'h30) || (item_char > 8'h39);

  assign put_in = (item_x[5:4] == 2'b00) && (item_y[4:3] == 2'b00);

  // glyph pixel (x + 2 - bit, y + row) for the current count
  assign gpos  = glyph_pos(ctrl.cnt);
  assign g_row = gpos[4:2];
  assign g_bit = gpos[1:0];
  assign g_idx = {item_char[3:0], 2'b00} + {2'b00, item_char[3:0]} + {3'b000, g_row};
  assign g_line = GLYPHS[g_idx];
  assign gx = {item_x[5], item_x} + 7'd2 - {5'b0, g_bit};
  assign gy = {item_y[4], item_y} + {3'b000, g_row};
  assign g_in = (gx[6:4] == 3'b000) && (gy[5:3] == 3'b000);

  always_comb begin
    wr_en = 1'b0;
    wr_col = item_x[3:0];
    wr_row = item_y[2:0];
    wr_val = item_on;
    case (ctrl.word.fb_op)
      FB_PUT: begin
        wr_en = put_in;
      end
      FB_GLYPH: begin
        wr_en = g_in;
        wr_col = gx[3:0];
        wr_row = gy[2:0];
        wr_val = g_line[g_bit];
      end
      default: begin
        wr_en = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int c = 0; c < 16; c++) fb[c] <= 8'h00;
    end else if (ctrl.advance) begin
      if (ctrl.word.fb_op == FB_CLEAR) begin
        for (int c = 0; c < 16; c++) fb[c] <= 8'h00;
      end else if (wr_en) begin
        fb[wr_col][wr_row] <= wr_val;
      end
    end
  end

  // refresh: even count is the far chip column, odd the near chip column
  assign rf_row = ctrl.cnt[3:1];
  assign rf_col = {ctrl.cnt[0], rf_row};

  always_comb begin
    n_word = 16'h0000;
    n_valid = 1'b0;
    n_fend = 1'b0;
    n_ok = 1'b1;
    n_last = ctrl.loop_done;
    case (ctrl.word.emit)
      EM_INIT: begin
        n_word = init_word(ctrl.cnt[3:1], inten);
        n_valid = 1'b1;
        n_fend = ctrl.cnt[0];
      end
      EM_REFRESH: begin
        n_word = {4'h0, {1'b0, rf_row} + 4'd1, fb[rf_col]};
        n_valid = 1'b1;
        n_fend = ctrl.cnt[0];
      end
      default: begin
        case (ctrl.word.ok_sel)
          OK_ZERO:  n_ok = 1'b0;
          OK_PIXEL: n_ok = put_in;
          default:  n_ok = 1'b1;
        endcase
      end
    endcase
  end

  assign emit_busy = out_valid && !out_ready;
  assign stat.stall = (ctrl.word.emit != EM_NONE) && emit_busy;
  assign load = ctrl.advance && (ctrl.word.emit != EM_NONE);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      spi_word <= n_word;
      word_valid <= n_valid;
      frame_end <= n_fend;
      ok <= n_ok;
      last <= n_last;
    end
  end

endmodule
